>>> src/bsa_pkg.sv
// Package for the safety allocator: status codes, actions, controller commands.
// No dependencies.
package bsa_pkg;
   localparam int MaxProcsDef = 8;
   localparam int NumResDef = 4;
   localparam int CountWidthDef = 8;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0, ACT_TOTALS = 2'd1, ACT_REQUEST = 2'd2, ACT_CHECK = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_LOADED = 3'd0, ST_ORDER = 3'd1, ST_UNSAFE = 3'd2,
      ST_NEED = 3'd3, ST_AVAIL = 3'd4, ST_INVALID = 3'd5
   } status_type;

   // datapath operations, one per controller step
   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_CAPTURE   = 4'd1,  // latch input item
      OP_LOAD_CHK  = 4'd2,  // check one resource of load row
      OP_LOAD_WR   = 4'd3,  // write one resource of load row
      OP_SUM       = 4'd4,  // accumulate alloc[p][r] into column sum
      OP_SUM_CHK   = 4'd5,  // compare column sum with total
      OP_AVAIL_WR  = 4'd6,  // write available[r]
      OP_REQ_CHK   = 4'd7,  // check request resource r
      OP_GRANT     = 4'd8,  // tentative grant on resource r
      OP_ROLLBACK  = 4'd9,  // undo grant on resource r
      OP_SAFE_INIT = 4'd10, // work = available, clear finished
      OP_FIT       = 4'd11, // test need[p][r] <= work[r]
      OP_RELEASE   = 4'd12  // work[r] += alloc[p][r]
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] proc;
      logic [1:0] res;
      logic       fin_set;
   } cmd_type;

   typedef struct packed {
      logic fail;      // last check failed
      logic fail_need; // request check failed on need
      logic finished;  // finished[proc]
   } stat_type;
endpackage

>>> src/bankers_safety_allocator_unit.sv
// Banker's algorithm allocator top level.
// Depends on bsa_pkg, bsa_controller, bsa_datapath.
// One transaction at a time, accepted only when idle with the result register
// empty. A bad process index on a load or request answers in the cycle after
// acceptance. A load row checks every resource, then writes every resource,
// answering before any write when an allocation is over its claim. Totals sum
// each resource column over the processes and compare it with the total, then
// write available. A request checks each resource in turn (a rejection answers
// once a resource fails), takes a turn step, grants each resource and sets up
// the check, then runs the safety check like a check transaction. Each round of
// the check passes over finished processes, tests each other one resource by
// resource, then releases the one that fits; the safe order then leaves one
// entry per cycle while the receiver is ready. An unsafe request is rolled back
// after its result, one resource per step, through the single shared lane.
module bankers_safety_allocator_unit import bsa_pkg::*; #(
   parameter int MAX_PROCS = MaxProcsDef,
   parameter int NUM_RES = NumResDef,
   parameter int COUNT_WIDTH = CountWidthDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   // process[2:0], amount0..3, alloc0..3 (8 bits each), 5 pad
   input  logic [71:0] req_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0]
   output logic [2:0]  rsp_tuser,
   // process_id[2:0], 5 pad
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);
   logic [3:0] np_ff;
   logic [2:0] nr_ff;
   cmd_type cmd;
   stat_type stat;
   logic [2:0] dp_proc, pid;

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff <= 4'd8; nr_ff <= 3'd4;
      end else if (csr_we) begin
         if (csr_index == 1'b0) np_ff <= csr_wdata;
         else nr_ff <= csr_wdata[2:0];
      end
   end

   bsa_controller #(.MAX_PROCS(MAX_PROCS), .NUM_RES(NUM_RES)) u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_action(req_tuser), .in_proc(req_tdata[2:0]),
      .np_cfg(np_ff), .nr_cfg(nr_ff), .cmd, .stat, .dp_proc,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_status(rsp_tuser), .out_pid(pid), .out_last(rsp_tlast));

   bsa_datapath #(.MAX_PROCS(MAX_PROCS), .NUM_RES(NUM_RES),
      .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock, .reset, .cmd, .in_proc(req_tdata[2:0]),
      .in_amount(req_tdata[34:3]), .in_alloc(req_tdata[66:35]),
      .stat, .cur_proc(dp_proc));

   assign rsp_tdata = {5'b00000, pid};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable({rsp_tuser, rsp_tdata, rsp_tlast}))
      else $error("result changed while waiting");
`endif
endmodule

>>> src/bsa_datapath.sv
// Datapath: tables, available, work, finished and one comparator/adder lane.
// Depends on bsa_pkg.
module bsa_datapath import bsa_pkg::*; #(
   parameter int MAX_PROCS = MaxProcsDef,
   parameter int NUM_RES = NumResDef,
   parameter int COUNT_WIDTH = CountWidthDef
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [2:0]  in_proc,
   input  logic [31:0] in_amount,
   input  logic [31:0] in_alloc,
   output stat_type    stat,
   output logic [2:0]  cur_proc
);
   localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int RW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
   localparam int IW = (MAX_PROCS * NUM_RES > 1) ? $clog2(MAX_PROCS * NUM_RES) : 1;
   localparam int SW = COUNT_WIDTH + 4;
   localparam logic [COUNT_WIDTH-1:0] CMax = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] max_mem [MAX_PROCS*NUM_RES];
   logic [COUNT_WIDTH-1:0] alloc_mem [MAX_PROCS*NUM_RES];
   logic [COUNT_WIDTH-1:0] avail_ff [NUM_RES];
   logic [COUNT_WIDTH-1:0] work_ff [NUM_RES];
   logic [MAX_PROCS-1:0]   fin_ff;
   logic [COUNT_WIDTH-1:0] amt_ff [NUM_RES];
   logic [COUNT_WIDTH-1:0] al_ff [NUM_RES];
   logic [2:0]             proc_ff;
   logic [SW-1:0]          sum_ff;
   logic                   fail_ff, need_ff;

   logic [PW-1:0] p;
   logic [RW-1:0] r;
   logic [IW-1:0] idx, ridx;
   logic [COUNT_WIDTH-1:0] mx, al, need, amt, wk, av;
   logic [COUNT_WIDTH:0] wsum;

   function automatic logic [COUNT_WIDTH-1:0] sat8(input logic [7:0] v);
      if (COUNT_WIDTH >= 8) return COUNT_WIDTH'(v);
      else if (v > 8'(CMax)) return CMax;
      else return COUNT_WIDTH'(v);
   endfunction

   assign p = PW'(cmd.proc);
   assign r = RW'(cmd.res);
   assign idx = IW'(p * NUM_RES + r);
   assign ridx = IW'(PW'(proc_ff) * NUM_RES + r);
   assign mx = max_mem[idx];
   assign al = alloc_mem[idx];
   assign need = mx - al;
   assign amt = amt_ff[r];
   assign wk = work_ff[r];
   assign av = avail_ff[r];
   assign wsum = {1'b0, wk} + {1'b0, al};
   assign stat = '{fail: fail_ff, fail_need: need_ff, finished: fin_ff[p]};
   assign cur_proc = proc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_RES; i++) begin
            avail_ff[i] <= '0;
            work_ff[i] <= '0;
         end
         fin_ff <= '0;
         fail_ff <= 1'b0;
         need_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_CAPTURE: begin
               proc_ff <= in_proc;
               for (int i = 0; i < NUM_RES; i++) begin
                  amt_ff[i] <= sat8(in_amount[8*i +: 8]);
                  al_ff[i] <= sat8(in_alloc[8*i +: 8]);
               end
               fail_ff <= 1'b0;
               need_ff <= 1'b0;
               sum_ff <= '0;
            end
            OP_LOAD_CHK: if (al_ff[r] > amt) fail_ff <= 1'b1;
            OP_LOAD_WR: begin
               max_mem[ridx] <= amt;
               alloc_mem[ridx] <= al_ff[r];
            end
            OP_SUM: sum_ff <= sum_ff + SW'(al);
            OP_SUM_CHK: begin
               if (sum_ff > SW'(amt)) fail_ff <= 1'b1;
               al_ff[r] <= COUNT_WIDTH'(sum_ff);
               sum_ff <= '0;
            end
            OP_AVAIL_WR: avail_ff[r] <= amt - al_ff[r];
            OP_REQ_CHK: begin
               if (amt > need) begin
                  fail_ff <= 1'b1;
                  need_ff <= 1'b1;
               end else if (amt > av) fail_ff <= 1'b1;
            end
            OP_GRANT: begin
               alloc_mem[idx] <= al + amt;
               avail_ff[r] <= av - amt;
            end
            OP_ROLLBACK: begin
               alloc_mem[idx] <= al - amt;
               avail_ff[r] <= av + amt;
            end
            OP_SAFE_INIT: begin
               for (int i = 0; i < NUM_RES; i++) work_ff[i] <= avail_ff[i];
               fin_ff <= '0;
               fail_ff <= 1'b0;
            end
            // resource 0 starts a fresh fit test for the process
            OP_FIT: fail_ff <= (need > wk) || ((r != '0) && fail_ff);
            OP_RELEASE: begin
               work_ff[r] <= wsum[COUNT_WIDTH] ? CMax : wsum[COUNT_WIDTH-1:0];
               if (cmd.fin_set) fin_ff[p] <= 1'b1;
               fail_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end
endmodule

>>> src/bsa_controller.sv
// Controller: sequences the datapath for each action and drives results.
// Depends on bsa_pkg.
module bsa_controller import bsa_pkg::*; #(
   parameter int MAX_PROCS = MaxProcsDef,
   parameter int NUM_RES = NumResDef
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [1:0] in_action,
   input  logic [2:0] in_proc,
   input  logic [3:0] np_cfg,
   input  logic [2:0] nr_cfg,
   output cmd_type    cmd,
   input  stat_type   stat,
   input  logic [2:0] dp_proc,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [2:0] out_status,
   output logic [2:0] out_pid,
   output logic       out_last
);
   localparam int PLim = (MAX_PROCS < 8) ? MAX_PROCS : 8;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_LOADC   = 14'b00000000000010,
      S_LOADW   = 14'b00000000000100,
      S_SUM     = 14'b00000000001000,
      S_SUMC    = 14'b00000000010000,
      S_AVW     = 14'b00000000100000,
      S_REQC    = 14'b00000001000000,
      S_GRANT   = 14'b00000010000000,
      S_SINIT   = 14'b00000100000000,
      S_FIT     = 14'b00001000000000,
      S_DEC     = 14'b00010000000000,
      S_REL     = 14'b00100000000000,
      S_EMIT    = 14'b01000000000000,
      S_ROLL    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] p_ff, p_in;
   logic [1:0] r_ff, r_in;
   logic [3:0] round_ff, round_in;   // processes finished, then emit position
   logic       req_ff, req_in;
   logic [7:0][2:0] order_ff, order_in;
   logic       ov_ff, ov_in;
   logic [2:0] os_ff, os_in, op_ff, op_in;
   logic       ol_ff, ol_in;
   logic [3:0] np;
   logic [1:0] nrm;
   logic       rlast, plast, rdone;

   assign np = (np_cfg == 4'd0) ? 4'd1 : (np_cfg > 4'(PLim)) ? 4'(PLim) : np_cfg;
   assign nrm = (nr_cfg == 3'd0) ? 2'd0 :
                (nr_cfg > 3'(NUM_RES)) ? 2'(NUM_RES - 1) : 2'(nr_cfg - 3'd1);
   assign rlast = (r_ff == nrm);
   assign plast = (p_ff == np - 4'd1);
   assign rdone = (round_ff == np - 4'd1);
   assign in_ready = (state_ff == S_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_status = os_ff;
   assign out_pid = op_ff;
   assign out_last = ol_ff;

   always_comb begin
      state_in = state_ff; p_in = p_ff; r_in = r_ff;
      round_in = round_ff; req_in = req_ff; order_in = order_ff;
      ov_in = ov_ff && !out_ready; os_in = os_ff; op_in = op_ff; ol_in = ol_ff;
      cmd = '{op: OP_NONE, proc: p_ff, res: r_ff, fin_set: 1'b0};
      unique case (state_ff)
         S_IDLE: if (in_valid && in_ready) begin
            cmd.op = OP_CAPTURE;
            r_in = '0; p_in = '0; req_in = 1'b0;
            unique case (action_type'(in_action))
               ACT_LOAD, ACT_REQUEST: begin
                  if ({1'b0, in_proc} >= np) begin
                     ov_in = 1'b1; os_in = ST_INVALID; op_in = '0; ol_in = 1'b1;
                  end else begin
                     p_in = {1'b0, in_proc};
                     state_in = (in_action == ACT_LOAD) ? S_LOADC : S_REQC;
                  end
               end
               ACT_TOTALS: state_in = S_SUM;
               default: state_in = S_SINIT;
            endcase
         end
         S_LOADC: begin
            cmd.op = OP_LOAD_CHK;
            if (rlast) begin r_in = '0; state_in = S_LOADW; end
            else r_in = r_ff + 2'd1;
         end
         S_LOADW: begin
            if (stat.fail) begin
               ov_in = 1'b1; os_in = ST_INVALID; op_in = '0; ol_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_LOAD_WR;
               if (rlast) begin
                  ov_in = 1'b1; os_in = ST_LOADED; op_in = '0; ol_in = 1'b1;
                  state_in = S_IDLE;
               end else r_in = r_ff + 2'd1;
            end
         end
         S_SUM: begin
            cmd.op = OP_SUM;
            if (plast) begin p_in = '0; state_in = S_SUMC; end
            else p_in = p_ff + 4'd1;
         end
         S_SUMC: begin
            cmd.op = OP_SUM_CHK;
            if (rlast) begin r_in = '0; state_in = S_AVW; end
            else begin r_in = r_ff + 2'd1; state_in = S_SUM; end
         end
         S_AVW: begin
            if (stat.fail) begin
               ov_in = 1'b1; os_in = ST_INVALID; op_in = '0; ol_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_AVAIL_WR;
               if (rlast) begin
                  ov_in = 1'b1; os_in = ST_LOADED; op_in = '0; ol_in = 1'b1;
                  state_in = S_IDLE;
               end else r_in = r_ff + 2'd1;
            end
         end
         S_REQC: begin
            // check fail from previous resource before checking the next
            if (stat.fail) begin
               ov_in = 1'b1; os_in = stat.fail_need ? ST_NEED : ST_AVAIL;
               op_in = '0; ol_in = 1'b1; state_in = S_IDLE;
            end else if (req_ff) begin
               req_in = 1'b0; r_in = '0; state_in = S_GRANT;
            end else begin
               cmd.op = OP_REQ_CHK;
               if (rlast) req_in = 1'b1;
               else r_in = r_ff + 2'd1;
            end
         end
         S_GRANT: begin
            cmd.op = OP_GRANT;
            if (rlast) begin r_in = '0; req_in = 1'b1; state_in = S_SINIT; end
            else r_in = r_ff + 2'd1;
         end
         S_SINIT: begin
            cmd.op = OP_SAFE_INIT;
            p_in = '0; r_in = '0; round_in = '0; state_in = S_FIT;
         end
         S_FIT: begin
            // finished processes are passed over; otherwise sweep the fit test
            if (stat.finished) begin
               r_in = '0;
               if (plast) begin
                  ov_in = 1'b1; os_in = ST_UNSAFE; op_in = '0; ol_in = 1'b1;
                  state_in = req_ff ? S_ROLL : S_IDLE;
               end else p_in = p_ff + 4'd1;
            end else begin
               cmd.op = OP_FIT;
               if (rlast) begin r_in = '0; state_in = S_DEC; end
               else r_in = r_ff + 2'd1;
            end
         end
         S_DEC: begin
            if (stat.fail) begin
               if (plast) begin
                  ov_in = 1'b1; os_in = ST_UNSAFE; op_in = '0; ol_in = 1'b1;
                  state_in = req_ff ? S_ROLL : S_IDLE;
               end else begin
                  p_in = p_ff + 4'd1; state_in = S_FIT;
               end
            end else begin
               order_in[round_ff[2:0]] = p_ff[2:0];
               state_in = S_REL;
            end
         end
         S_REL: begin
            cmd.op = OP_RELEASE; cmd.fin_set = 1'b1;
            if (rlast) begin
               r_in = '0; p_in = '0;
               if (rdone) begin round_in = '0; state_in = S_EMIT; end
               else begin round_in = round_ff + 4'd1; state_in = S_FIT; end
            end else r_in = r_ff + 2'd1;
         end
         S_EMIT: begin
            // one safe order entry per free output slot
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1; os_in = ST_ORDER; op_in = order_ff[round_ff[2:0]];
               ol_in = rdone;
               if (rdone) state_in = S_IDLE;
               else round_in = round_ff + 4'd1;
            end
         end
         S_ROLL: begin
            cmd.op = OP_ROLLBACK; cmd.proc = {1'b0, dp_proc};
            if (rlast) state_in = S_IDLE;
            else r_in = r_ff + 2'd1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; p_ff <= '0; r_ff <= '0;
         round_ff <= '0; req_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; p_ff <= p_in; r_ff <= r_in;
         round_ff <= round_in; req_ff <= req_in; ov_ff <= ov_in;
      end
      os_ff <= os_in; op_ff <= op_in; ol_ff <= ol_in; order_ff <= order_in;
   end
endmodule
